[hdl/gnst_pkg.sv]
// Shared types and constants of the gated nearest seed tracker.
// No dependencies; every other file of the block refers to it by scoped names.
package gnst_pkg;

    // Field widths fixed by the stream format
    localparam int OP_W      = 2;
    localparam int CI_W      = 6;
    localparam int EX_W      = 7;
    localparam int HALF_W    = 15;
    localparam int REG_W     = 16;
    localparam int DIFF_W    = 16;
    localparam int SQ_W      = 31;
    localparam int SCORE_W   = 32;
    localparam int CFG_IDX_W = 3;

    // Request kinds carried in tuser
    typedef enum logic [OP_W-1:0] {
        OP_POINT  = 2'd0,
        OP_LAST   = 2'd1,
        OP_END    = 2'd2,
        OP_RESEED = 2'd3
    } t_op;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE    = 3'd5;

    // Register values after reset
    localparam logic [HALF_W-1:0] RST_HALF_X  = 15'd512;
    localparam logic [HALF_W-1:0] RST_HALF_Y  = 15'd256;
    localparam logic [REG_W-1:0]  RST_INIT_X  = 16'd0;
    localparam logic [REG_W-1:0]  RST_LEFT_Y  = 16'd384;
    localparam logic [REG_W-1:0]  RST_RIGHT_Y = 16'hFE80;
    localparam logic              RST_SIDE    = 1'b0;

    // Cluster code meaning "no cluster"
    localparam logic signed [EX_W-1:0] NO_CLUSTER = -7'sd1;

    // Configuration register file contents
    typedef struct packed {
        logic [HALF_W-1:0] half_x;
        logic [HALF_W-1:0] half_y;
        logic [REG_W-1:0]  init_x;
        logic [REG_W-1:0]  left_y;
        logic [REG_W-1:0]  right_y;
        logic              side;
    } t_cfg;

    // Control flags of one point as it moves down the pipeline
    typedef struct packed {
        logic            frame_end;
        logic            point;
        logic            cand;
        logic [CI_W-1:0] ci;
    } t_pt_ctl;

endpackage

[hdl/gnst_cfg.sv]
// Configuration register file of the gated nearest seed tracker.
// Depends on gnst_pkg for the register indexes, reset values and t_cfg.
module gnst_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [gnst_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [gnst_pkg::REG_W-1:0]     i_data,
    output logic                           o_ready,
    output gnst_pkg::t_cfg                 o_cfg
);

    gnst_pkg::t_cfg r_cfg;

    // Writes are taken in any cycle.
    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_x  <= gnst_pkg::RST_HALF_X;
            r_cfg.half_y  <= gnst_pkg::RST_HALF_Y;
            r_cfg.init_x  <= gnst_pkg::RST_INIT_X;
            r_cfg.left_y  <= gnst_pkg::RST_LEFT_Y;
            r_cfg.right_y <= gnst_pkg::RST_RIGHT_Y;
            r_cfg.side    <= gnst_pkg::RST_SIDE;
        end else if (i_valid) begin
            case (i_index)
                gnst_pkg::CFG_HALF_X:  r_cfg.half_x  <= i_data[gnst_pkg::HALF_W-1:0];
                gnst_pkg::CFG_HALF_Y:  r_cfg.half_y  <= i_data[gnst_pkg::HALF_W-1:0];
                gnst_pkg::CFG_INIT_X:  r_cfg.init_x  <= i_data;
                gnst_pkg::CFG_LEFT_Y:  r_cfg.left_y  <= i_data;
                gnst_pkg::CFG_RIGHT_Y: r_cfg.right_y <= i_data;
                gnst_pkg::CFG_SIDE:    r_cfg.side    <= i_data[0];
                default: ;
            endcase
        end
    end

endmodule

[hdl/gnst_gate.sv]
// Input stage of the tracker: request register, per-cluster minimum x memory,
// seen bits, exclusion and window test. Depends on gnst_pkg.
module gnst_gate #(
    parameter int MAX_CLUSTERS = 64,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_accept,
    input  gnst_pkg::t_op                       i_op,
    input  logic signed [COORD_WIDTH-1:0]       i_px,
    input  logic signed [COORD_WIDTH-1:0]       i_py,
    input  logic [gnst_pkg::CI_W-1:0]           i_ci,
    input  logic signed [gnst_pkg::EX_W-1:0]    i_ex,
    input  gnst_pkg::t_cfg                      i_cfg,
    input  logic signed [COORD_WIDTH-1:0]       i_seed_x,
    input  logic signed [COORD_WIDTH-1:0]       i_seed_y,
    output gnst_pkg::t_pt_ctl                   o_md,
    output logic signed [COORD_WIDTH-1:0]       o_md_min,
    output logic signed [gnst_pkg::DIFF_W-1:0]  o_md_dx,
    output logic signed [gnst_pkg::DIFF_W-1:0]  o_md_dy,
    output logic                                o_in_fe,
    output logic                                o_reseed
);

    localparam int AW = $clog2(MAX_CLUSTERS);
    localparam int WW = ((COORD_WIDTH > gnst_pkg::DIFF_W) ? COORD_WIDTH : gnst_pkg::DIFF_W) + 2;

    // Request register
    logic                             r_in_valid;
    gnst_pkg::t_op                    r_in_op;
    logic signed [COORD_WIDTH-1:0]    r_in_px;
    logic signed [COORD_WIDTH-1:0]    r_in_py;
    logic [gnst_pkg::CI_W-1:0]        r_in_ci;
    logic signed [gnst_pkg::EX_W-1:0] r_in_ex;
    logic signed [COORD_WIDTH-1:0]    r_rd;

    // Per-cluster state
    logic signed [COORD_WIDTH-1:0]    r_min_x [MAX_CLUSTERS];
    logic [MAX_CLUSTERS-1:0]          r_seen;

    // Output stage registers
    gnst_pkg::t_pt_ctl                r_md;
    logic signed [COORD_WIDTH-1:0]    r_md_min;
    logic signed [gnst_pkg::DIFF_W-1:0] r_md_dx;
    logic signed [gnst_pkg::DIFF_W-1:0] r_md_dy;

    logic [AW-1:0]                    rd_addr;
    logic [AW-1:0]                    wr_addr;
    logic                             in_range;
    logic                             is_point;
    logic                             frame_end;
    logic                             seen;
    logic signed [COORD_WIDTH-1:0]    min_after;
    logic                             wr_en;
    logic                             excluded;
    logic signed [WW-1:0]             dx;
    logic signed [WW-1:0]             dy;
    logic signed [WW-1:0]             half_x;
    logic signed [WW-1:0]             half_y;
    logic                             in_window;
    logic                             cand;

    // Decode of the held request
    always_comb begin
        rd_addr   = AW'(i_ci);
        wr_addr   = AW'(r_in_ci);
        in_range  = 32'(r_in_ci) < MAX_CLUSTERS;
        is_point  = r_in_valid && in_range &&
                    (r_in_op == gnst_pkg::OP_POINT || r_in_op == gnst_pkg::OP_LAST);
        frame_end = r_in_valid &&
                    (r_in_op == gnst_pkg::OP_LAST || r_in_op == gnst_pkg::OP_END);
        seen      = in_range && r_seen[wr_addr];
        min_after = (!seen || r_in_px < r_rd) ? r_in_px : r_rd;
        wr_en     = i_en && is_point;
    end

    // Exclusion and inclusive rectangle around the seed
    always_comb begin
        excluded  = !r_in_ex[gnst_pkg::EX_W-1] &&
                    (r_in_ex[gnst_pkg::CI_W-1:0] == r_in_ci);
        half_x    = $signed(WW'(i_cfg.half_x));
        half_y    = $signed(WW'(i_cfg.half_y));
        dx        = WW'(r_in_px) - WW'(i_seed_x);
        dy        = WW'(r_in_py) - WW'(i_seed_y);
        in_window = (dx >= -half_x) && (dx <= half_x) &&
                    (dy >= -half_y) && (dy <= half_y);
        cand      = is_point && !excluded && in_window;
    end

    // Request register; the memory read is taken at acceptance, with the
    // write of the same edge passed around the memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_en) begin
            r_in_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_in_op <= i_op;
            r_in_px <= i_px;
            r_in_py <= i_py;
            r_in_ci <= i_ci;
            r_in_ex <= i_ex;
            r_rd    <= (wr_en && wr_addr == rd_addr) ? min_after : r_min_x[rd_addr];
        end
    end

    // Minimum x memory write
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_min_x[wr_addr] <= min_after;
        end
    end

    // Seen bits, cleared at once by a frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (i_en) begin
            if (frame_end) begin
                r_seen <= '0;
            end else if (is_point) begin
                r_seen[wr_addr] <= 1'b1;
            end
        end
    end

    // Stage register toward the squaring stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_md <= '0;
        end else if (i_en) begin
            r_md.frame_end <= frame_end;
            r_md.point     <= is_point;
            r_md.cand      <= cand;
            r_md.ci        <= r_in_ci;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_md_min <= min_after;
            r_md_dx  <= dx[gnst_pkg::DIFF_W-1:0];
            r_md_dy  <= dy[gnst_pkg::DIFF_W-1:0];
        end
    end

    assign o_md     = r_md;
    assign o_md_min = r_md_min;
    assign o_md_dx  = r_md_dx;
    assign o_md_dy  = r_md_dy;
    assign o_in_fe  = frame_end;
    assign o_reseed = i_en && r_in_valid && (r_in_op == gnst_pkg::OP_RESEED);

endmodule

[hdl/gnst_square.sv]
// Squaring stage of the tracker: squares both offsets of a point to the seed.
// Depends on gnst_pkg for widths and the point control struct.
module gnst_square #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  gnst_pkg::t_pt_ctl                  i_md,
    input  logic signed [COORD_WIDTH-1:0]      i_min,
    input  logic signed [gnst_pkg::DIFF_W-1:0] i_dx,
    input  logic signed [gnst_pkg::DIFF_W-1:0] i_dy,
    output gnst_pkg::t_pt_ctl                  o_sq,
    output logic signed [COORD_WIDTH-1:0]      o_min,
    output logic [gnst_pkg::SQ_W-1:0]          o_sqx,
    output logic [gnst_pkg::SQ_W-1:0]          o_sqy
);

    gnst_pkg::t_pt_ctl                       r_sq;
    logic signed [COORD_WIDTH-1:0]           r_min;
    logic [gnst_pkg::SQ_W-1:0]               r_sqx;
    logic [gnst_pkg::SQ_W-1:0]               r_sqy;
    logic signed [2*gnst_pkg::DIFF_W-1:0]    prod_x;
    logic signed [2*gnst_pkg::DIFF_W-1:0]    prod_y;

    // Squares are never negative and at most 2^30.
    always_comb begin
        prod_x = i_dx * i_dx;
        prod_y = i_dy * i_dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq <= '0;
        end else if (i_en) begin
            r_sq <= i_md;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_min <= i_min;
            r_sqx <= prod_x[gnst_pkg::SQ_W-1:0];
            r_sqy <= prod_y[gnst_pkg::SQ_W-1:0];
        end
    end

    assign o_sq  = r_sq;
    assign o_min = r_min;
    assign o_sqx = r_sqx;
    assign o_sqy = r_sqy;

endmodule

[hdl/gnst_track.sv]
// Tracking stage: best candidate of the frame, seed state and result register.
// Depends on gnst_pkg for widths, codes and the point control struct.
module gnst_track #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  gnst_pkg::t_pt_ctl                 i_sq,
    input  logic signed [COORD_WIDTH-1:0]     i_min,
    input  logic [gnst_pkg::SQ_W-1:0]         i_sqx,
    input  logic [gnst_pkg::SQ_W-1:0]         i_sqy,
    input  logic                              i_reseed,
    input  gnst_pkg::t_cfg                    i_cfg,
    input  logic                              i_m_tready,
    output logic                              o_stall,
    output logic signed [COORD_WIDTH-1:0]     o_seed_x,
    output logic signed [COORD_WIDTH-1:0]     o_seed_y,
    output logic                              o_valid,
    output logic signed [gnst_pkg::EX_W-1:0]  o_matched,
    output logic signed [COORD_WIDTH-1:0]     o_out_x,
    output logic signed [COORD_WIDTH-1:0]     o_out_y,
    output logic                              o_flag
);

    // Seed state
    logic signed [COORD_WIDTH-1:0]     r_seed_x;
    logic signed [COORD_WIDTH-1:0]     r_seed_y;
    logic                              r_flag;

    // Best candidate of the running frame, with its cluster's current minimum x
    logic                              r_best_valid;
    logic [gnst_pkg::SCORE_W-1:0]      r_best_dist;
    logic [gnst_pkg::CI_W-1:0]         r_best_ci;
    logic signed [COORD_WIDTH-1:0]     r_best_min;

    // Result register
    logic                              r_out_valid;
    logic signed [gnst_pkg::EX_W-1:0]  r_out_matched;
    logic signed [COORD_WIDTH-1:0]     r_out_x;
    logic signed [COORD_WIDTH-1:0]     r_out_y;
    logic                              r_out_flag;

    logic [gnst_pkg::SCORE_W-1:0]      score;
    logic                              win;
    logic                              same;
    logic                              n_best_valid;
    logic [gnst_pkg::SCORE_W-1:0]      n_best_dist;
    logic [gnst_pkg::CI_W-1:0]         n_best_ci;
    logic signed [COORD_WIDTH-1:0]     n_best_min;
    logic                              load;

    // Score and best update for the point in this stage
    always_comb begin
        score        = gnst_pkg::SCORE_W'(i_sqx) + gnst_pkg::SCORE_W'(i_sqy);
        win          = i_sq.cand && (score < r_best_dist);
        same         = i_sq.point && r_best_valid && (i_sq.ci == r_best_ci);
        n_best_valid = r_best_valid || win;
        n_best_dist  = win ? score : r_best_dist;
        n_best_ci    = win ? i_sq.ci : r_best_ci;
        n_best_min   = (win || same) ? i_min : r_best_min;
    end

    // A frame end holds the pipeline only while the last result is not taken.
    assign o_stall = i_sq.frame_end && r_out_valid && !i_m_tready;
    assign load    = i_en && i_sq.frame_end;

    // Frame accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid <= 1'b0;
            r_best_dist  <= '1;
        end else if (i_en) begin
            if (i_sq.frame_end) begin
                r_best_valid <= 1'b0;
                r_best_dist  <= '1;
            end else begin
                r_best_valid <= n_best_valid;
                r_best_dist  <= n_best_dist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_best_ci  <= n_best_ci;
            r_best_min <= n_best_min;
        end
    end

    // Seed update on a match and reload on a reseed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_x <= COORD_WIDTH'(gnst_pkg::RST_INIT_X);
            r_seed_y <= COORD_WIDTH'(gnst_pkg::RST_SIDE ? gnst_pkg::RST_RIGHT_Y
                                                          : gnst_pkg::RST_LEFT_Y);
            r_flag   <= 1'b0;
        end else if (i_reseed) begin
            r_seed_x <= COORD_WIDTH'(i_cfg.init_x);
            r_seed_y <= COORD_WIDTH'(i_cfg.side ? i_cfg.right_y : i_cfg.left_y);
            r_flag   <= 1'b0;
        end else if (load && n_best_valid) begin
            r_seed_x <= n_best_min;
            r_flag   <= 1'b1;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_matched <= n_best_valid ? $signed({1'b0, n_best_ci})
                                          : gnst_pkg::NO_CLUSTER;
            r_out_x       <= n_best_valid ? n_best_min : r_seed_x;
            r_out_y       <= r_seed_y;
            r_out_flag    <= n_best_valid || r_flag;
        end
    end

    assign o_seed_x  = r_seed_x;
    assign o_seed_y  = r_seed_y;
    assign o_valid   = r_out_valid;
    assign o_matched = r_out_matched;
    assign o_out_x   = r_out_x;
    assign o_out_y   = r_out_y;
    assign o_flag    = r_out_flag;

endmodule

[hdl/gated_nearest_seed_tracker.sv]
// Top level of the gated nearest seed tracker.
// Depends on gnst_pkg, gnst_cfg, gnst_gate, gnst_square and gnst_track.
//
//  channel   direction  handshake                  payload
//  i_s_*     in         i_s_tvalid / o_s_tready    tdata: x, y, cluster, excluded; tuser: kind
//  o_m_*     out        o_m_tvalid / i_m_tready    tdata: cluster, seed x, seed y, matched
//  i_cfg_*   in         i_cfg_valid / o_cfg_ready  register index and data
//
// One request is taken per cycle while the pipeline does not stall. A frame-ending
// request (last point or empty frame end) holds off input while it is in the request
// register or the stage register after it, since the seed that it may move is written
// in the last stage, two stages after the window test, where its result is also registered.
// Reset clears all control state at once; there is no clearing pass.
// A waiting result stalls input only when the next frame end reaches the last stage.
module gated_nearest_seed_tracker #(
    parameter int MAX_CLUSTERS = 64,
    parameter int COORD_WIDTH  = 16,
    localparam int IN_W  = ((2 * COORD_WIDTH + gnst_pkg::CI_W + gnst_pkg::EX_W + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_WIDTH + gnst_pkg::EX_W + 1 + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // Fields from bit 0: point_x, point_y, cluster_index, excluded_cluster, zero fill
    input  logic [IN_W-1:0]                i_s_tdata,
    // Fields from bit 0: operation
    input  logic [gnst_pkg::OP_W-1:0]      i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // Fields from bit 0: matched_cluster, seed_x_out, seed_y_out, seed_matched, zero fill
    output logic [OUT_W-1:0]               o_m_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gnst_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gnst_pkg::REG_W-1:0]     i_cfg_data
);

    localparam int CI_LO = 2 * COORD_WIDTH;
    localparam int EX_LO = CI_LO + gnst_pkg::CI_W;

    gnst_pkg::t_cfg                      cfg;
    gnst_pkg::t_pt_ctl                   md;
    gnst_pkg::t_pt_ctl                   sq;
    logic signed [COORD_WIDTH-1:0]       md_min;
    logic signed [gnst_pkg::DIFF_W-1:0]  md_dx;
    logic signed [gnst_pkg::DIFF_W-1:0]  md_dy;
    logic signed [COORD_WIDTH-1:0]       sq_min;
    logic [gnst_pkg::SQ_W-1:0]           sq_x;
    logic [gnst_pkg::SQ_W-1:0]           sq_y;
    logic signed [COORD_WIDTH-1:0]       seed_x;
    logic signed [COORD_WIDTH-1:0]       seed_y;
    logic signed [gnst_pkg::EX_W-1:0]    out_matched;
    logic signed [COORD_WIDTH-1:0]       out_x;
    logic signed [COORD_WIDTH-1:0]       out_y;
    logic                                out_flag;
    logic                                in_fe;
    logic                                reseed;
    logic                                stall;
    logic                                en;
    logic                                accept;

    // Pipeline advance and input gating
    assign en         = !stall;
    assign o_s_tready = en && !in_fe && !md.frame_end;
    assign accept     = i_s_tvalid && o_s_tready;

    gnst_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_ready (o_cfg_ready),
        .o_cfg   (cfg)
    );

    gnst_gate #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_gate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_accept (accept),
        .i_op     (gnst_pkg::t_op'(i_s_tuser)),
        .i_px     ($signed(i_s_tdata[COORD_WIDTH-1:0])),
        .i_py     ($signed(i_s_tdata[CI_LO-1:COORD_WIDTH])),
        .i_ci     (i_s_tdata[EX_LO-1:CI_LO]),
        .i_ex     ($signed(i_s_tdata[EX_LO+gnst_pkg::EX_W-1:EX_LO])),
        .i_cfg    (cfg),
        .i_seed_x (seed_x),
        .i_seed_y (seed_y),
        .o_md     (md),
        .o_md_min (md_min),
        .o_md_dx  (md_dx),
        .o_md_dy  (md_dy),
        .o_in_fe  (in_fe),
        .o_reseed (reseed)
    );

    gnst_square #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_md    (md),
        .i_min   (md_min),
        .i_dx    (md_dx),
        .i_dy    (md_dy),
        .o_sq    (sq),
        .o_min   (sq_min),
        .o_sqx   (sq_x),
        .o_sqy   (sq_y)
    );

    gnst_track #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_sq       (sq),
        .i_min      (sq_min),
        .i_sqx      (sq_x),
        .i_sqy      (sq_y),
        .i_reseed   (reseed),
        .i_cfg      (cfg),
        .i_m_tready (i_m_tready),
        .o_stall    (stall),
        .o_seed_x   (seed_x),
        .o_seed_y   (seed_y),
        .o_valid    (o_m_tvalid),
        .o_matched  (out_matched),
        .o_out_x    (out_x),
        .o_out_y    (out_y),
        .o_flag     (out_flag)
    );

    // Result packing, zero filled to whole bytes
    assign o_m_tdata = OUT_W'({out_flag, out_y, out_x, out_matched});

endmodule

[tb/gated_nearest_seed_tracker_tb.sv]
// Self-checking testbench of the gated nearest seed tracker.
// Depends on gnst_pkg and gated_nearest_seed_tracker; a scoreboard class predicts
// every frame result; plain tasks drive the request and register channels.
module gated_nearest_seed_tracker_tb;

    localparam int CLUSTERS       = 64;
    localparam int IN_W           = 48;
    localparam int OUT_W          = 40;
    localparam int COORD_MIN      = -32768;
    localparam int COORD_MAX      = 32767;
    localparam int SETTLE_CYCLES  = 8;
    localparam int IDLE_LIMIT     = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 113;
    localparam int PRESSURE_PHASE = 4;
    localparam int NO_EX          = int'(gnst_pkg::NO_CLUSTER);

    // Register index outside the defined set; a write to it must change nothing.
    localparam logic [gnst_pkg::CFG_IDX_W-1:0] SPARE_REG = 3'd7;

    // One request on the input stream.
    typedef struct {
        gnst_pkg::t_op                    op;
        logic signed [gnst_pkg::REG_W-1:0] px;
        logic signed [gnst_pkg::REG_W-1:0] py;
        logic [gnst_pkg::CI_W-1:0]        ci;
        logic signed [gnst_pkg::EX_W-1:0] ex;
    } t_point_req;

    // One frame result as it appears on the output stream.
    typedef struct packed {
        logic                        flag;
        logic [gnst_pkg::REG_W-1:0]  sy;
        logic [gnst_pkg::REG_W-1:0]  sx;
        logic [gnst_pkg::EX_W-1:0]   cluster;
    } t_frame_result;

    // Tracks seed, frame accumulators and registers, and holds the frame
    // results still owed by the block.
    class seed_scoreboard;
        logic [gnst_pkg::HALF_W-1:0]  half_x;
        logic [gnst_pkg::HALF_W-1:0]  half_y;
        logic [gnst_pkg::REG_W-1:0]   init_x;
        logic [gnst_pkg::REG_W-1:0]   left_y;
        logic [gnst_pkg::REG_W-1:0]   right_y;
        logic                         side;
        int                           seed_x;
        int                           seed_y;
        bit                           seed_locked;
        logic [gnst_pkg::SCORE_W-1:0] best_score;
        int                           best_cluster;
        int                           cluster_min_x [CLUSTERS];
        bit                           cluster_seen [CLUSTERS];
        t_frame_result                owed_results [$];
        int                           errors;

        function new();
            half_x  = gnst_pkg::RST_HALF_X;
            half_y  = gnst_pkg::RST_HALF_Y;
            init_x  = gnst_pkg::RST_INIT_X;
            left_y  = gnst_pkg::RST_LEFT_Y;
            right_y = gnst_pkg::RST_RIGHT_Y;
            side    = gnst_pkg::RST_SIDE;
            errors  = 0;
            restore_seed();
            clear_frame();
        endfunction

        function void restore_seed();
            seed_x      = int'($signed(init_x));
            seed_y      = side ? int'($signed(right_y)) : int'($signed(left_y));
            seed_locked = 1'b0;
        endfunction

        function void clear_frame();
            best_score   = '1;
            best_cluster = -1;
            foreach (cluster_seen[k]) cluster_seen[k] = 1'b0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        function void note_config(logic [gnst_pkg::CFG_IDX_W-1:0] idx,
                                  logic [gnst_pkg::REG_W-1:0] data);
            case (idx)
                gnst_pkg::CFG_HALF_X:  half_x  = data[gnst_pkg::HALF_W-1:0];
                gnst_pkg::CFG_HALF_Y:  half_y  = data[gnst_pkg::HALF_W-1:0];
                gnst_pkg::CFG_INIT_X:  init_x  = data;
                gnst_pkg::CFG_LEFT_Y:  left_y  = data;
                gnst_pkg::CFG_RIGHT_Y: right_y = data;
                gnst_pkg::CFG_SIDE:    side    = data[0];
                default: ;
            endcase
        endfunction

        // Minimum x is kept for every point; scoring only for candidates
        // inside the inclusive window and not in the excluded cluster.
        function void take_point(t_point_req r);
            int                           px;
            int                           py;
            int                           ci;
            longint                       dx;
            longint                       dy;
            logic [gnst_pkg::SCORE_W-1:0] score;
            px = int'(r.px);
            py = int'(r.py);
            ci = int'(r.ci);
            if (!cluster_seen[ci] || px < cluster_min_x[ci]) cluster_min_x[ci] = px;
            cluster_seen[ci] = 1'b1;
            if (int'(r.ex) == ci) return;
            if (px < seed_x - int'(half_x) || px > seed_x + int'(half_x)) return;
            if (py < seed_y - int'(half_y) || py > seed_y + int'(half_y)) return;
            dx    = longint'(px - seed_x);
            dy    = longint'(py - seed_y);
            score = gnst_pkg::SCORE_W'(dx * dx + dy * dy);
            if (score < best_score) begin
                best_score   = score;
                best_cluster = ci;
            end
        endfunction

        function void note_request(t_point_req r);
            t_frame_result res;
            if (r.op == gnst_pkg::OP_RESEED) begin
                restore_seed();
                return;
            end
            if (r.op == gnst_pkg::OP_POINT || r.op == gnst_pkg::OP_LAST) take_point(r);
            if (r.op == gnst_pkg::OP_POINT) return;
            // Frame end: a match moves the seed to the cluster's leftmost point.
            if (best_cluster >= 0 && cluster_seen[best_cluster]) begin
                seed_x      = cluster_min_x[best_cluster];
                seed_locked = 1'b1;
            end
            res.cluster = best_cluster[gnst_pkg::EX_W-1:0];
            res.sx      = seed_x[gnst_pkg::REG_W-1:0];
            res.sy      = seed_y[gnst_pkg::REG_W-1:0];
            res.flag    = seed_locked;
            owed_results.push_back(res);
            clear_frame();
        endfunction

        task check_result(logic [OUT_W-1:0] data);
            t_frame_result got;
            t_frame_result want;
            got = data[$bits(t_frame_result)-1:0];
            if (owed_results.size() == 0) begin
                report($sformatf("result with no frame end waiting, data %h", data));
                return;
            end
            want = owed_results.pop_front();
            if (got.cluster !== want.cluster)
                report($sformatf("matched cluster %0d, expected %0d",
                                 $signed(got.cluster), $signed(want.cluster)));
            if (got.sx !== want.sx)
                report($sformatf("seed x %0d, expected %0d",
                                 $signed(got.sx), $signed(want.sx)));
            if (got.sy !== want.sy)
                report($sformatf("seed y %0d, expected %0d",
                                 $signed(got.sy), $signed(want.sy)));
            if (got.flag !== want.flag)
                report($sformatf("match flag %b, expected %b", got.flag, want.flag));
        endtask

        task check_drained();
            if (owed_results.size() != 0)
                report($sformatf("%0d frame results never arrived", owed_results.size()));
        endtask
    endclass

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           s_tvalid    = 1'b0;
    logic [IN_W-1:0]                s_tdata     = '0;
    logic [gnst_pkg::OP_W-1:0]      s_tuser     = '0;
    logic                           m_tready    = 1'b0;
    logic                           cfg_valid   = 1'b0;
    logic [gnst_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [gnst_pkg::REG_W-1:0]     cfg_data    = '0;
    logic                           o_s_tready;
    logic                           o_m_tvalid;
    logic [OUT_W-1:0]               o_m_tdata;
    logic                           o_cfg_ready;

    seed_scoreboard sb;
    int             sent_count    = 0;
    int             hold_requests = 0;
    bit             burst_mode    = 1'b0;
    int             idle_cycles   = 0;

    gated_nearest_seed_tracker u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Result receiver: random stalls, runs of steady ready, and long holds on request.
    initial begin
        int unsigned run_left;
        int unsigned pick;
        int          hold_served;
        run_left    = 0;
        hold_served = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (hold_served != hold_requests) begin
                    hold_served = hold_requests;
                    m_tready   <= 1'b0;
                    run_left    = LONG_HOLD;
                end else if (run_left != 0) begin
                    run_left--;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50) begin
                        m_tready <= 1'b1;
                        run_left  = $urandom_range(1, 40);
                    end else if (pick < 90) begin
                        m_tready <= 1'b0;
                        run_left  = $urandom_range(1, 3);
                    end else begin
                        m_tready <= 1'b0;
                        run_left  = $urandom_range(10, 30);
                    end
                end
            end
        end
    end

    // Every accepted result is checked against the oldest owed frame result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready) sb.check_result(o_m_tdata);
    end

    // Watchdog on cycles without any accepted request on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("gated_nearest_seed_tracker_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one request after a random gap and waits until it is taken.
    task automatic push(input t_point_req r);
        int unsigned gap;
        int unsigned pick;
        gap  = 0;
        pick = $urandom_range(0, 19);
        if (!burst_mode) begin
            if (pick >= 19) gap = $urandom_range(8, 25);
            else if (pick >= 13) gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - 2 * gnst_pkg::REG_W - gnst_pkg::CI_W - gnst_pkg::EX_W){1'b0}},
                     r.ex, r.ci, r.py, r.px};
        s_tuser  <= r.op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(r);
        sent_count++;
    endtask

    task automatic push_fields(input gnst_pkg::t_op op, input int x, input int y,
                               input int ci, input int ex);
        t_point_req r;
        r.op = op;
        r.px = x[gnst_pkg::REG_W-1:0];
        r.py = y[gnst_pkg::REG_W-1:0];
        r.ci = ci[gnst_pkg::CI_W-1:0];
        r.ex = ex[gnst_pkg::EX_W-1:0];
        push(r);
    endtask

    // Register write; valid stays high so back-to-back writes need no gap.
    task automatic write_reg(input logic [gnst_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gnst_pkg::REG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.note_config(idx, data);
    endtask

    task automatic load_config(input logic [gnst_pkg::REG_W-1:0] hx,
                               input logic [gnst_pkg::REG_W-1:0] hy,
                               input logic [gnst_pkg::REG_W-1:0] ix,
                               input logic [gnst_pkg::REG_W-1:0] ly,
                               input logic [gnst_pkg::REG_W-1:0] ry,
                               input logic [gnst_pkg::REG_W-1:0] sd);
        write_reg(gnst_pkg::CFG_HALF_X, hx);
        write_reg(gnst_pkg::CFG_HALF_Y, hy);
        write_reg(gnst_pkg::CFG_INIT_X, ix);
        write_reg(gnst_pkg::CFG_LEFT_Y, ly);
        write_reg(gnst_pkg::CFG_RIGHT_Y, ry);
        write_reg(gnst_pkg::CFG_SIDE, sd);
    endtask

    // Waits until every frame result is in and the pipeline has emptied.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Coordinate near the window edges or inside the window around a center.
    function automatic logic [gnst_pkg::REG_W-1:0] near_coord(input int center,
                                                              input int half);
        int v;
        case ($urandom_range(0, 7))
            0: v = center - half - 1;
            1: v = center - half;
            2: v = center + half;
            3: v = center + half + 1;
            default: v = center + int'($urandom_range(0, 2 * half + 4)) - half - 2;
        endcase
        if (v < COORD_MIN) v = COORD_MIN;
        if (v > COORD_MAX) v = COORD_MAX;
        return v[gnst_pkg::REG_W-1:0];
    endfunction

    function automatic t_point_req make_point(input gnst_pkg::t_op op, input bit noisy,
                                              input int unsigned base,
                                              input logic signed [gnst_pkg::EX_W-1:0] ex);
        t_point_req r;
        r.op = op;
        r.ex = ex;
        if (noisy || op == gnst_pkg::OP_END || op == gnst_pkg::OP_RESEED) begin
            r.px = gnst_pkg::REG_W'($urandom);
            r.py = gnst_pkg::REG_W'($urandom);
        end else begin
            r.px = near_coord(sb.seed_x, int'(sb.half_x));
            r.py = near_coord(sb.seed_y, int'(sb.half_y));
        end
        if ($urandom_range(0, 4) == 0) r.ci = gnst_pkg::CI_W'($urandom);
        else r.ci = gnst_pkg::CI_W'(base + $urandom_range(0, 3));
        return r;
    endfunction

    // One frame: a few points of nearby clusters, sometimes a reseed inside,
    // closed by a last point or an empty frame end.
    task automatic random_frame(input int unsigned max_pts);
        int unsigned                      npts;
        int unsigned                      base;
        bit                               noisy;
        logic signed [gnst_pkg::EX_W-1:0] ex;
        npts  = $urandom_range(0, max_pts);
        base  = $urandom_range(0, CLUSTERS - 1);
        noisy = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 3))
            0: ex = {1'b0, gnst_pkg::CI_W'(base + $urandom_range(0, 3))};
            1: ex = gnst_pkg::EX_W'($urandom);
            default: ex = gnst_pkg::NO_CLUSTER;
        endcase
        for (int unsigned k = 0; k < npts; k++) begin
            if ($urandom_range(0, 29) == 0)
                push(make_point(gnst_pkg::OP_RESEED, 1'b1, base, ex));
            push(make_point(gnst_pkg::OP_POINT, noisy, base, ex));
        end
        if (npts == 0 || $urandom_range(0, 3) == 0)
            push(make_point(gnst_pkg::OP_END, 1'b1, base, ex));
        else
            push(make_point(gnst_pkg::OP_LAST, noisy, base, ex));
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames with the reset registers: seed at (0, 384),
        // window half extents 512 by 256.
        push_fields(gnst_pkg::OP_END, 0, 0, 0, NO_EX);
        push_fields(gnst_pkg::OP_POINT, 0, 384, 7, NO_EX);
        push_fields(gnst_pkg::OP_POINT, 0, 384, 9, NO_EX);        // equal score, first stays
        push_fields(gnst_pkg::OP_POINT, -300, 32767, 7, NO_EX);   // out of window, sets min x
        push_fields(gnst_pkg::OP_LAST, 32767, 32767, 63, NO_EX);
        push_fields(gnst_pkg::OP_POINT, 212, 640, 5, 5);          // excluded cluster
        push_fields(gnst_pkg::OP_POINT, 212, 640, 6, 5);          // upper corner, inclusive
        push_fields(gnst_pkg::OP_POINT, 213, 384, 4, 5);          // one step past x edge
        push_fields(gnst_pkg::OP_POINT, -300, 127, 4, 5);         // one step below y edge
        push_fields(gnst_pkg::OP_LAST, -812, 128, 3, 5);          // lower corner, equal score
        push_fields(gnst_pkg::OP_RESEED, 32767, -32768, 63, 63);
        push_fields(gnst_pkg::OP_END, -32768, 32767, 63, -64);
        push_fields(gnst_pkg::OP_POINT, 0, 384, 63, 63);
        push_fields(gnst_pkg::OP_POINT, 10, 384, 62, -64);        // negative excluded: none
        push_fields(gnst_pkg::OP_POINT, 5, 384, 61, -64);
        push_fields(gnst_pkg::OP_RESEED, 0, 0, 0, NO_EX);         // mid-frame, keeps the best
        push_fields(gnst_pkg::OP_END, 0, 0, 0, NO_EX);
        push_fields(gnst_pkg::OP_POINT, 5, 384, 0, NO_EX);
        push_fields(gnst_pkg::OP_POINT, -32768, 0, 0, NO_EX);
        push_fields(gnst_pkg::OP_LAST, 32767, -32768, 1, NO_EX);
        push_fields(gnst_pkg::OP_RESEED, 0, 0, 0, NO_EX);
        push_fields(gnst_pkg::OP_END, 0, 0, 0, NO_EX);

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: load_config('0, '0, gnst_pkg::REG_W'($urandom), gnst_pkg::REG_W'($urandom),
                               gnst_pkg::REG_W'($urandom), '0);
                1: load_config(16'h7FFF, 16'h7FFF, 16'h8000, gnst_pkg::REG_W'($urandom),
                               16'h7FFF, 16'h0001);
                2: load_config(gnst_pkg::REG_W'($urandom_range(0, 2048)),
                               gnst_pkg::REG_W'($urandom_range(0, 1024)), 16'h7FFF,
                               16'h8000, gnst_pkg::REG_W'($urandom), '0);
                default: load_config(gnst_pkg::REG_W'(($urandom_range(0, 3) == 0)
                                         ? $urandom : $urandom_range(0, 2048)),
                                     gnst_pkg::REG_W'(($urandom_range(0, 3) == 0)
                                         ? $urandom : $urandom_range(0, 2048)),
                                     gnst_pkg::REG_W'($urandom), gnst_pkg::REG_W'($urandom),
                                     gnst_pkg::REG_W'($urandom), gnst_pkg::REG_W'($urandom));
            endcase
            if (ph == 3) write_reg(SPARE_REG, gnst_pkg::REG_W'($urandom));
            cfg_valid <= 1'b0;
            if (ph < 2 || $urandom_range(0, 3) != 0)
                push(make_point(gnst_pkg::OP_RESEED, 1'b1, 0, gnst_pkg::NO_CLUSTER));

            // Long receiver hold while short frames keep arriving back to back.
            if (ph == PRESSURE_PHASE) begin
                hold_requests++;
                burst_mode = 1'b1;
                repeat (24) random_frame(1);
            end

            while (sent_count < 22 + (ph + 1) * PHASE_ITEMS) begin
                burst_mode = ($urandom_range(0, 4) == 0);
                random_frame(10);
            end
            burst_mode = 1'b0;
        end

        settle();
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("gated_nearest_seed_tracker_tb: done, clean");
        end else begin
            $display("gated_nearest_seed_tracker_tb: done, errors");
        end
        $finish;
    end

endmodule
